@@ hdl/text_console_writer_top_assert.svh @@
// Assertion macros for the text console writer.
// Each check is sampled on the rising edge of clk and is ignored while arst_n is low.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define TCW_ASSERT(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("text console writer: check failed");
`define TCW_ASSERT_NEXT(name, trig, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error("text console writer: check failed one cycle later");
`else
`define TCW_ASSERT(name, prop)
`define TCW_ASSERT_NEXT(name, trig, cons)
`endif

`endif

@@ hdl/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

	localparam int ROWS       = 25;
	localparam int COLUMNS    = 80;
	localparam int TAB_WIDTH  = 4;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int SUM_W  = COL_W + 1;
	localparam int ADDR_W = 11;
	localparam int CHAR_W = 8;
	localparam int CELL_W = 16;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_HOME      = 8'h9C;

	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COPY,
		ST_BLANK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic item_go;
		logic cnt_clr;
		logic cnt_inc;
		logic copy_step;
		logic blank_step;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic scroll_req;
		logic cnt_copy_end;
		logic cnt_last;
	} dp_status_t;

	function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		logic [ADDR_W-1:0] base;
		base = ADDR_W'(ADDR_W'(row) * ADDR_W'(COLUMNS));
		return ADDR_W'(base + ADDR_W'(col));
	endfunction

endpackage

`default_nettype wire

@@ hdl/tcw_ctrl.sv @@
`default_nettype none

module tcw_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tcw_pkg::ctl_cmd_t     cmd,
	input  tcw_pkg::dp_status_t   status
);

	tcw_pkg::state_t state_q;
	tcw_pkg::state_t state_d;
	logic            out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			tcw_pkg::ST_CLEAR: begin
				cmd.blank_step = 1'b1;
				if (status.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = tcw_pkg::ST_IDLE;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.item_go = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = status.scroll_req ? tcw_pkg::ST_COPY : tcw_pkg::ST_FINISH;
				end
			end
			tcw_pkg::ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (status.cnt_copy_end) begin
					state_d = tcw_pkg::ST_BLANK;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			tcw_pkg::ST_BLANK: begin
				cmd.blank_step = 1'b1;
				if (status.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = tcw_pkg::ST_FINISH;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			tcw_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_CLEAR;
			end
		endcase
	end

	assign in_ready  = (state_q == tcw_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/tcw_dp.sv @@
`default_nettype none

module tcw_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          func,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::CHAR_W-1:0]    attribute,
	input  logic [tcw_pkg::ADDR_W-1:0]    read_address,
	input  tcw_pkg::ctl_cmd_t             cmd,
	output tcw_pkg::dp_status_t           status,
	output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
	output logic [tcw_pkg::COL_W-1:0]     cursor_col,
	output logic [tcw_pkg::ADDR_W-1:0]    cursor_linear,
	output logic [tcw_pkg::CELL_W-1:0]    read_data
);

	logic [tcw_pkg::CELL_W-1:0] mem [tcw_pkg::CELL_COUNT];

	logic [tcw_pkg::ROW_W-1:0]  row_q;
	logic [tcw_pkg::COL_W-1:0]  col_q;
	logic [tcw_pkg::ADDR_W-1:0] cnt_q;
	logic [tcw_pkg::CELL_W-1:0] rdata_q;
	logic                       rd_hit_q;

	logic [tcw_pkg::ROW_W-1:0]  out_row_q;
	logic [tcw_pkg::COL_W-1:0]  out_col_q;
	logic [tcw_pkg::ADDR_W-1:0] out_lin_q;
	logic [tcw_pkg::CELL_W-1:0] out_data_q;

	logic                       at_last;
	logic [tcw_pkg::ROW_W-1:0]  row_adv;
	logic [tcw_pkg::SUM_W-1:0]  tab_sum;
	logic [tcw_pkg::SUM_W-1:0]  tab_off;
	logic [tcw_pkg::COL_W-1:0]  tab_col;
	logic [tcw_pkg::ROW_W-1:0]  nxt_row;
	logic [tcw_pkg::COL_W-1:0]  nxt_col;
	logic                       scroll;
	logic                       wr_item;
	logic [tcw_pkg::ADDR_W-1:0] item_addr;
	logic [tcw_pkg::CELL_W-1:0] item_data;
	logic                       rd_in_range;

	logic                       mem_we;
	logic [tcw_pkg::ADDR_W-1:0] mem_waddr;
	logic [tcw_pkg::CELL_W-1:0] mem_wdata;
	logic                       rd_en;
	logic [tcw_pkg::ADDR_W-1:0] rd_addr;

	// Next cursor position and cell write for a write item.
	always_comb begin
		at_last   = (row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
		row_adv   = at_last ? row_q : tcw_pkg::ROW_W'(row_q + 1'b1);
		tab_sum   = tcw_pkg::SUM_W'(col_q) + tcw_pkg::SUM_W'(tcw_pkg::TAB_WIDTH);
		tab_off   = tcw_pkg::SUM_W'(tab_sum - tcw_pkg::SUM_W'(tcw_pkg::COLUMNS - 1));
		tab_col   = (tab_off > tcw_pkg::SUM_W'(tcw_pkg::COLUMNS - 1)) ?
			tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1) : tcw_pkg::COL_W'(tab_off);
		nxt_row   = row_q;
		nxt_col   = col_q;
		scroll    = 1'b0;
		wr_item   = 1'b0;
		item_addr = tcw_pkg::cell_index(row_q, col_q);
		item_data = {attribute, char_code};
		case (char_code)
			tcw_pkg::CH_NEWLINE: begin
				nxt_row = row_adv;
				nxt_col = '0;
				scroll  = at_last;
			end
			tcw_pkg::CH_TAB: begin
				if (tab_sum > tcw_pkg::SUM_W'(tcw_pkg::COLUMNS - 1)) begin
					nxt_row = row_adv;
					nxt_col = tab_col;
					scroll  = at_last;
				end else begin
					nxt_col = tcw_pkg::COL_W'(tab_sum);
				end
			end
			tcw_pkg::CH_BACKSPACE: begin
				if (col_q == '0) begin
					if (row_q != '0) begin
						nxt_row = tcw_pkg::ROW_W'(row_q - 1'b1);
						nxt_col = tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1);
						wr_item = 1'b1;
					end
				end else begin
					nxt_col = tcw_pkg::COL_W'(col_q - 1'b1);
					wr_item = 1'b1;
				end
				item_addr = tcw_pkg::cell_index(nxt_row, nxt_col);
				item_data = tcw_pkg::BLANK_CELL;
			end
			tcw_pkg::CH_HOME: begin
				nxt_row = '0;
				nxt_col = '0;
			end
			default: begin
				wr_item = 1'b1;
				if (col_q == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1)) begin
					nxt_row = row_adv;
					nxt_col = '0;
					scroll  = at_last;
				end else begin
					nxt_col = tcw_pkg::COL_W'(col_q + 1'b1);
				end
			end
		endcase
	end

	assign rd_in_range = (read_address < tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT));

	assign status.scroll_req   = !func && scroll;
	assign status.cnt_copy_end = (cnt_q == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS));
	assign status.cnt_last     = (cnt_q == tcw_pkg::ADDR_W'(tcw_pkg::CELL_COUNT - 1));

	// The copy writes the cell read in the cycle before, which was read from one line further down.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q;
		mem_wdata = tcw_pkg::BLANK_CELL;
		if (cmd.item_go && !func && wr_item) begin
			mem_we    = 1'b1;
			mem_waddr = item_addr;
			mem_wdata = item_data;
		end else if (cmd.copy_step && cnt_q != '0) begin
			mem_we    = 1'b1;
			mem_waddr = tcw_pkg::ADDR_W'(cnt_q - 1'b1);
			mem_wdata = rdata_q;
		end else if (cmd.blank_step) begin
			mem_we = 1'b1;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = read_address;
		if (cmd.item_go && func && rd_in_range) begin
			rd_en = 1'b1;
		end else if (cmd.copy_step && !status.cnt_copy_end) begin
			rd_en   = 1'b1;
			rd_addr = tcw_pkg::ADDR_W'(cnt_q + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS));
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.item_go && !func) begin
				row_q <= nxt_row;
				col_q <= nxt_col;
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= tcw_pkg::ADDR_W'(cnt_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.item_go) begin
			rd_hit_q <= func && rd_in_range;
		end
		if (cmd.out_load) begin
			out_row_q  <= row_q;
			out_col_q  <= col_q;
			out_lin_q  <= tcw_pkg::cell_index(row_q, col_q);
			out_data_q <= rd_hit_q ? rdata_q : '0;
		end
	end

	assign cursor_row    = out_row_q;
	assign cursor_col    = out_col_q;
	assign cursor_linear = out_lin_q;
	assign read_data     = out_data_q;

endmodule

`default_nettype wire

@@ hdl/text_console_writer_top.sv @@
// Results: after a beat is accepted, the finish state loads its result into the result register;
// a result still waiting downstream holds the next one back.
// Beats are taken only in the idle state; the cell store is read through a register.
// A write that passes the last row adds a scroll: the line copy, then blanking of the last row.
// Reset: arst_n clears the cursor and control at once, then a clearing pass fills every cell
// with 0x0F20 while in_ready stays low.
`default_nettype none

`include "text_console_writer_top_assert.svh"

module text_console_writer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [tcw_pkg::CHAR_W-1:0]    attribute,
	input  logic [tcw_pkg::ADDR_W-1:0]    read_address,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tcw_pkg::ROW_W-1:0]     cursor_row,
	output logic [tcw_pkg::COL_W-1:0]     cursor_col,
	output logic [tcw_pkg::ADDR_W-1:0]    cursor_linear,
	output logic [tcw_pkg::CELL_W-1:0]    read_data
);

	// The controller sequences the clearing pass, each item and any scroll; the datapath
	// owns the cell store, the cursor and the result register.
	tcw_pkg::ctl_cmd_t   cmd;
	tcw_pkg::dp_status_t status;

	// Terms used by the checks at the end of the module.
	logic                cursor_fits;
	logic                linear_fits;

	// The result register lets a new beat be taken while the previous result still waits.
	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Characters are stored in the cycle the beat is accepted; a scroll then copies the
	// store up one line, one cell per cycle, and blanks the bottom line.
	tcw_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.func          (func),
		.char_code     (char_code),
		.attribute     (attribute),
		.read_address  (read_address),
		.cmd           (cmd),
		.status        (status),
		.cursor_row    (cursor_row),
		.cursor_col    (cursor_col),
		.cursor_linear (cursor_linear),
		.read_data     (read_data)
	);

	assign cursor_fits = (cursor_row <= tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) &&
		(cursor_col <= tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
	assign linear_fits = (cursor_linear == tcw_pkg::cell_index(cursor_row, cursor_col));

	// The reported cursor always lies on the screen.
	`TCW_ASSERT(a_cursor_on_screen, out_valid |-> cursor_fits)
	// The linear position agrees with the row and column reported beside it.
	`TCW_ASSERT(a_linear_matches, out_valid |-> linear_fits)
	// Only one item is in work at a time.
	`TCW_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

endmodule

`default_nettype wire

@@ dv/text_console_writer_top_test.sv @@
`default_nettype none

module text_console_writer_top_test;

	import tcw_pkg::*;

	// Item kinds carried on the func input.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_READ  = 1'b1;

	localparam int ITEM_TARGET = 1800;
	// The long receiver hold-off starts once this many beats have gone in.
	localparam int HOLD_AFTER  = 300;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int PRINT_CAP   = 100;

	// The cursor report that every beat produces on the output side.
	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [ADDR_W-1:0] linear;
		logic [CELL_W-1:0] data;
	} cursor_report_t;

	// Shadow copy of the screen store and the cursor. Input beats are applied
	// to it as they are accepted; each one leaves an expected cursor report in
	// a queue that the output side drains in order.
	class console_shadow;
		logic [CELL_W-1:0] cells [CELL_COUNT];
		int cur_row;
		int cur_col;
		cursor_report_t reports_due [$];
		int errors;
		int noted;
		int checked;
		int cell_reads;
		int scrolls;

		function new();
			foreach (cells[i])
				cells[i] = BLANK_CELL;
			cur_row = 0;
			cur_col = 0;
			errors = 0;
			noted = 0;
			checked = 0;
			cell_reads = 0;
			scrolls = 0;
		endfunction

		task report(input string what, input logic [CELL_W-1:0] got,
			input logic [CELL_W-1:0] want);
			errors++;
			if (errors <= PRINT_CAP)
				$display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
		endtask

		// Move down one row, scrolling the whole store up when the cursor
		// would fall off the bottom.
		function void next_line();
			cur_row++;
			if (cur_row > ROWS - 1) begin
				for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
					cells[i] = cells[i + COLUMNS];
				for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
					cells[i] = BLANK_CELL;
				cur_row = ROWS - 1;
				cur_col = 0;
				scrolls++;
			end
		endfunction

		function void apply_char(input logic [CHAR_W-1:0] ch, input logic [CHAR_W-1:0] attr);
			int spill;
			case (ch)
				CH_NEWLINE: begin
					next_line();
					cur_col = 0;
				end
				CH_TAB: begin
					if (cur_col + TAB_WIDTH > COLUMNS - 1) begin
						// The overshoot past the last column carries onto the next row.
						spill = cur_col + TAB_WIDTH - (COLUMNS - 1);
						next_line();
						cur_col = (spill > COLUMNS - 1) ? COLUMNS - 1 : spill;
					end else begin
						cur_col += TAB_WIDTH;
					end
				end
				CH_BACKSPACE: begin
					if (cur_row == 0 && cur_col == 0)
						return;
					if (cur_col == 0) begin
						cur_row--;
						cur_col = COLUMNS - 1;
					end else begin
						cur_col--;
					end
					cells[cur_row * COLUMNS + cur_col] = BLANK_CELL;
				end
				CH_HOME: begin
					cur_row = 0;
					cur_col = 0;
				end
				default: begin
					cells[cur_row * COLUMNS + cur_col] = {attr, ch};
					cur_col++;
					if (cur_col > COLUMNS - 1) begin
						cur_col = 0;
						next_line();
					end
				end
			endcase
		endfunction

		function void note_item(input logic f, input logic [CHAR_W-1:0] ch,
			input logic [CHAR_W-1:0] attr, input logic [ADDR_W-1:0] addr);
			cursor_report_t r;
			r.data = '0;
			if (f == FUNC_WRITE) begin
				apply_char(ch, attr);
			end else begin
				cell_reads++;
				if (addr < CELL_COUNT)
					r.data = cells[addr];
			end
			r.row = ROW_W'(cur_row);
			r.col = COL_W'(cur_col);
			r.linear = ADDR_W'(cur_row * COLUMNS + cur_col);
			reports_due.push_back(r);
			noted++;
		endfunction

		task check_report(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
			input logic [ADDR_W-1:0] linear, input logic [CELL_W-1:0] data);
			cursor_report_t want;
			if (reports_due.size() == 0) begin
				report("result beat with nothing outstanding", data, '0);
				return;
			end
			want = reports_due.pop_front();
			checked++;
			if (row !== want.row)
				report("cursor_row", CELL_W'(row), CELL_W'(want.row));
			if (col !== want.col)
				report("cursor_col", CELL_W'(col), CELL_W'(want.col));
			if (linear !== want.linear)
				report("cursor_linear", CELL_W'(linear), CELL_W'(want.linear));
			if (data !== want.data)
				report("read_data", data, want.data);
		endtask
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                func = FUNC_WRITE;
	logic [CHAR_W-1:0]   char_code = '0;
	logic [CHAR_W-1:0]   attribute = '0;
	logic [ADDR_W-1:0]   read_address = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [ROW_W-1:0]    cursor_row;
	logic [COL_W-1:0]    cursor_col;
	logic [ADDR_W-1:0]   cursor_linear;
	logic [CELL_W-1:0]   read_data;

	console_shadow sb;
	// While calm is set neither side inserts idle or stall cycles.
	bit calm = 1'b0;
	int cycles = 0;

	text_console_writer_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.char_code    (char_code),
		.attribute    (attribute),
		.read_address (read_address),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cursor_row   (cursor_row),
		.cursor_col   (cursor_col),
		.cursor_linear(cursor_linear),
		.read_data    (read_data)
	);

	always #4 clk = ~clk;

	// Watchdog: a run that has not finished by now has hung somewhere.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("text_console_writer_top: mismatch");
			$finish;
		end
	end

	// Result side. Outputs are sampled at the edge itself, so the values seen
	// here are the ones that were stable before it.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			sb.check_report(cursor_row, cursor_col, cursor_linear, read_data);
	end

	// Receiver pacing runs in its own process. Early on it refuses results
	// for a long stretch so that the block backs up and drops in_ready while
	// the sender keeps offering beats; afterwards it stalls in random bursts.
	initial begin : sink_pacing
		bit held_off;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && sb.noted >= HOLD_AFTER) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (calm || $urandom_range(0, 2) != 0) begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
		end
	end

	// Offer one beat and hold it until the block takes it. Valid is left
	// high on return so that back-to-back beats need no second assignment in
	// the same step; an idle burst lowers it first when one is drawn.
	task automatic offer(input logic f, input logic [CHAR_W-1:0] ch,
		input logic [CHAR_W-1:0] attr, input logic [ADDR_W-1:0] addr);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		char_code <= ch;
		attribute <= attr;
		read_address <= addr;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.note_item(f, ch, attr, addr);
	endtask

	// Write beats carry a random address and reads a random byte and
	// attribute, so the unused fields still see every bit move.
	task automatic type_char(input logic [CHAR_W-1:0] ch);
		offer(FUNC_WRITE, ch, CHAR_W'($urandom), ADDR_W'($urandom));
	endtask

	task automatic peek_cell(input int addr);
		offer(FUNC_READ, CHAR_W'($urandom), CHAR_W'($urandom), ADDR_W'(addr));
	endtask

	function automatic logic [CHAR_W-1:0] plain_char();
		return CHAR_W'($urandom_range(8'h20, 8'h7E));
	endfunction

	function automatic logic [CHAR_W-1:0] control_char();
		case ($urandom_range(0, 3))
			0:       return CH_NEWLINE;
			1:       return CH_TAB;
			2:       return CH_BACKSPACE;
			default: return CH_HOME;
		endcase
	endfunction

	// Tab across to the right-hand edge, then leave the row either by one
	// more tab or by plain characters until the column wraps.
	task automatic run_to_edge();
		while (sb.cur_col < COLUMNS - TAB_WIDTH)
			type_char(CH_TAB);
		if ($urandom_range(0, 1) == 0)
			type_char(CH_TAB);
		else
			do type_char(plain_char()); while (sb.cur_col != 0);
	endtask

	initial begin : stimulus
		int kind;
		int addr;
		bit first;

		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: the store straight after reset, reads at and past
		// the end of the store, extreme bytes and attributes, and each cursor
		// move including its awkward corners.
		peek_cell(0);
		peek_cell(CELL_COUNT - 1);
		peek_cell(CELL_COUNT);
		peek_cell(2 ** ADDR_W - 1);
		offer(FUNC_WRITE, 8'h41, 8'hFF, '0);
		offer(FUNC_WRITE, 8'h00, 8'h00, '1);
		offer(FUNC_WRITE, 8'hFF, 8'h80, '0);
		peek_cell(0);
		peek_cell(2);
		// Backspace blanks the cell it lands on.
		type_char(CH_BACKSPACE);
		peek_cell(2);
		type_char(CH_TAB);
		type_char(CH_HOME);
		// Backspace at home leaves everything as it was.
		type_char(CH_BACKSPACE);
		// Backspace from column 0 goes to the end of the row above; a tab
		// from there wraps onto the next row at the overshoot.
		type_char(CH_NEWLINE);
		type_char(CH_BACKSPACE);
		type_char(CH_TAB);
		// A plain character in the last column wraps the cursor.
		type_char(CH_HOME);
		type_char(CH_NEWLINE);
		type_char(CH_BACKSPACE);
		offer(FUNC_WRITE, 8'h5A, 8'h1E, '0);
		peek_cell(COLUMNS - 1);

		// Random part, built from short sequences. The first one always runs
		// the cursor down to the bottom so that a scroll happens early.
		first = 1'b1;
		while (sb.noted < ITEM_TARGET) begin
			calm = (sb.noted >= 700 && sb.noted < 850) || sb.noted >= 1550;
			kind = first ? 99 : $urandom_range(0, 99);
			first = 1'b0;
			if (kind < 55) begin
				// A run of text with some controls, stray bytes and peeks
				// around the cursor mixed in.
				repeat ($urandom_range(1, 16)) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4, 5: type_char(plain_char());
						6: type_char(CHAR_W'($urandom));
						7: begin
							addr = sb.cur_row * COLUMNS + sb.cur_col
								+ int'($urandom_range(0, 6)) - 3;
							peek_cell(addr < 0 ? 0 : addr);
						end
						default: type_char(control_char());
					endcase
				end
			end else if (kind < 70) begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 3))
						0: peek_cell($urandom_range(CELL_COUNT - COLUMNS, CELL_COUNT - 1));
						1: peek_cell($urandom_range(CELL_COUNT, 2 ** ADDR_W - 1));
						default: peek_cell($urandom_range(0, CELL_COUNT - 1));
					endcase
				end
			end else if (kind < 78) begin
				type_char(CH_HOME);
				if ($urandom_range(0, 1) == 0)
					type_char(CH_BACKSPACE);
			end else if (kind < 87) begin
				repeat ($urandom_range(1, 6))
					type_char(CH_BACKSPACE);
				peek_cell(sb.cur_row * COLUMNS + sb.cur_col);
			end else if (kind < 95) begin
				run_to_edge();
			end else begin
				// Down to the last row, then leave it by a newline or at the edge.
				while (sb.cur_row < ROWS - 1)
					type_char(CH_NEWLINE);
				if ($urandom_range(0, 1) == 0)
					type_char(CH_NEWLINE);
				else
					run_to_edge();
				peek_cell($urandom_range(CELL_COUNT - 2 * COLUMNS, CELL_COUNT - 1));
			end
		end
		in_valid <= 1'b0;

		// Drain, then give the block a little longer to show any stray beat.
		while (sb.reports_due.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Covered %0d beats (%0d cell reads, %0d scrolls); %0d cursor reports checked.",
			sb.noted, sb.cell_reads, sb.scrolls, sb.checked);
		if (sb.errors == 0)
			$display("text_console_writer_top: match");
		else
			$display("text_console_writer_top: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
